// ----- rtl/piecewise_linear_interpolator_core_defines.svh -----
// Assertion macros shared by the interpolator checker.
// Needs nothing else; included by bare file name.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication
`define PLI_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLI_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pli_pkg.sv -----
// Types and constants for the piecewise linear interpolator.
// No dependencies; used by every module of the block.
`default_nettype none

package pli_pkg;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] RS_INSIDE = 2'd0;
   localparam logic [1:0] RS_BELOW  = 2'd1;
   localparam logic [1:0] RS_ABOVE  = 2'd2;
   localparam logic [1:0] RS_ZERO   = 2'd3;

   localparam int STEP_W    = 6;
   localparam int DIV_STEPS = 48;
   localparam int MUL_STEPS = 3;

   typedef struct packed {
      logic               opcode;
      logic [5:0]         point_index;
      logic [31:0]        x_value;
      logic signed [31:0] y_load;
   } req_type;

   typedef struct packed {
      logic signed [31:0] y_result;
      logic [1:0]         range_status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BASE,
      ST_SCAN,
      ST_LOW,
      ST_HIGH,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_SEG,
      RD_NEXT,
      RD_PREV
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       base;
      logic       scan;
      logic       fetch_lo;
      logic       fetch_hi;
      logic       prep;
      logic       div_step;
      logic       mul_step;
      logic       sum;
      logic       emit;
      rd_sel_type rd_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic seg_done;
      logic seg_zero;
      logic div_last;
      logic mul_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/pli_ctl.sv -----
// Sequencer for the interpolator: load, scan, fetch, divide, multiply, emit.
// Depends on pli_pkg; drives pli_dp through command and status structs.
`default_nettype none

module pli_ctl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_is_query,
   input  pli_pkg::dp_status_type  status,
   output logic                    req_ready,
   output pli_pkg::dp_cmd_type     cmd
);

   pli_pkg::ctl_state_type state_ff;
   pli_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pli_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (req_valid && req_is_query) state_in = pli_pkg::ST_BASE;
         end
         pli_pkg::ST_BASE: state_in = pli_pkg::ST_SCAN;
         pli_pkg::ST_SCAN: begin
            if (status.seg_done) state_in = pli_pkg::ST_LOW;
         end
         pli_pkg::ST_LOW:  state_in = pli_pkg::ST_HIGH;
         pli_pkg::ST_HIGH: state_in = pli_pkg::ST_PREP;
         pli_pkg::ST_PREP: begin
            state_in = status.seg_zero ? pli_pkg::ST_DONE : pli_pkg::ST_DIV;
         end
         pli_pkg::ST_DIV: begin
            if (status.div_last) state_in = pli_pkg::ST_MUL;
         end
         pli_pkg::ST_MUL: begin
            if (status.mul_last) state_in = pli_pkg::ST_SUM;
         end
         pli_pkg::ST_SUM:  state_in = pli_pkg::ST_DONE;
         pli_pkg::ST_DONE: begin
            if (status.out_free) state_in = pli_pkg::ST_IDLE;
         end
         default: state_in = pli_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = pli_pkg::RD_ZERO;
      unique case (state_ff)
         pli_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && !req_is_query;
            cmd.start = req_valid && req_is_query;
         end
         pli_pkg::ST_BASE: begin
            cmd.base   = 1'b1;
            cmd.rd_sel = pli_pkg::RD_SEG;
         end
         pli_pkg::ST_SCAN: begin
            cmd.scan   = 1'b1;
            cmd.rd_sel = status.seg_done ? pli_pkg::RD_PREV : pli_pkg::RD_NEXT;
         end
         pli_pkg::ST_LOW: begin
            cmd.fetch_lo = 1'b1;
            cmd.rd_sel   = pli_pkg::RD_SEG;
         end
         pli_pkg::ST_HIGH: cmd.fetch_hi = 1'b1;
         pli_pkg::ST_PREP: cmd.prep     = 1'b1;
         pli_pkg::ST_DIV:  cmd.div_step = 1'b1;
         pli_pkg::ST_MUL:  cmd.mul_step = 1'b1;
         pli_pkg::ST_SUM:  cmd.sum      = 1'b1;
         pli_pkg::ST_DONE: cmd.emit     = status.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/pli_dp.sv -----
// Datapath: breakpoint memories, scan index, restoring divider, 16x32
// multiplier, saturating adder and result register. Depends on pli_pkg.
`default_nettype none

module pli_dp #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  pli_pkg::dp_cmd_type     cmd,
   output pli_pkg::dp_status_type  status,
   input  pli_pkg::req_type        req_data,
   input  wire                     csr_wr,
   input  wire [6:0]               csr_point_count,
   input  wire                     rsp_ready,
   output logic                    rsp_valid,
   output pli_pkg::rsp_type        rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [31:0]        x_mem [TABLE_DEPTH];
   logic [31:0]        y_mem [TABLE_DEPTH];
   logic [31:0]        x_rd_ff;
   logic [31:0]        y_rd_ff;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        wr_idx;
   logic               wr_ok;

   logic [6:0]         pc_ff;
   logic [31:0]        pc_ext;
   logic [31:0]        n_cnt;
   logic [31:0]        n_last;

   logic [31:0]        x_ff;
   logic [AW-1:0]      idx_ff;
   logic [AW-1:0]      n_last_ff;
   logic               below_ff;
   logic               above_ff;
   logic               hit;
   logic               last;

   logic [31:0]        x0_ff;
   logic signed [31:0] y0_ff;
   logic signed [32:0] dx_ff;
   logic signed [32:0] num_ff;
   logic signed [32:0] dy_ff;

   logic [31:0]        div_ff;
   logic [31:0]        mdy_ff;
   logic               neg_ff;
   logic [31:0]        rem_ff;
   logic [47:0]        q_ff;
   logic [79:0]        acc_ff;
   logic [pli_pkg::STEP_W-1:0] cnt_ff;
   logic [32:0]        trial;
   logic [32:0]        diff;
   logic               ge;
   logic [47:0]        pp;

   logic [63:0]        mp;
   logic               big;
   logic [34:0]        y0e;
   logic [34:0]        mpe;
   logic [34:0]        s;
   logic signed [31:0] sum_val;

   logic signed [31:0] res_ff;
   logic [1:0]         stat_ff;
   logic               rsp_valid_ff;
   pli_pkg::rsp_type   rsp_data_ff;

   function automatic logic [31:0] mag33(input logic [32:0] v);
      logic [32:0] n;
      n = ~v + 33'd1;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

   // table write and registered read
   assign wr_idx = 32'(req_data.point_index);
   assign wr_ok  = wr_idx < 32'(TABLE_DEPTH);

   always_comb begin
      unique case (cmd.rd_sel)
         pli_pkg::RD_ZERO: rd_addr = '0;
         pli_pkg::RD_SEG:  rd_addr = idx_ff;
         pli_pkg::RD_NEXT: rd_addr = idx_ff + AW'(1);
         pli_pkg::RD_PREV: rd_addr = idx_ff - AW'(1);
         default:          rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         x_mem[wr_idx[AW-1:0]] <= req_data.x_value;
         y_mem[wr_idx[AW-1:0]] <= req_data.y_load;
      end
      x_rd_ff <= x_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   // point count register, clamped to 2 .. TABLE_DEPTH on use
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 7'd2;
      end else if (csr_wr) begin
         pc_ff <= csr_point_count;
      end
   end

   assign pc_ext = 32'(pc_ff);
   assign n_cnt  = (pc_ext < 32'd2) ? 32'd2 :
                   (pc_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : pc_ext;
   assign n_last = n_cnt - 32'd1;

   // scan
   assign hit  = x_rd_ff >= x_ff;
   assign last = idx_ff == n_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff      <= req_data.x_value;
         n_last_ff <= n_last[AW-1:0];
         idx_ff    <= AW'(1);
      end
      if (cmd.base) begin
         below_ff <= x_ff < x_rd_ff;
      end
      if (cmd.scan) begin
         if (hit || last) begin
            above_ff <= !hit;
         end else begin
            idx_ff <= idx_ff + AW'(1);
         end
      end
      if (cmd.fetch_lo) begin
         x0_ff <= x_rd_ff;
         y0_ff <= y_rd_ff;
      end
      if (cmd.fetch_hi) begin
         dx_ff  <= $signed({1'b0, x_rd_ff}) - $signed({1'b0, x0_ff});
         num_ff <= $signed({1'b0, x_ff}) - $signed({1'b0, x0_ff});
         dy_ff  <= $signed({y_rd_ff[31], y_rd_ff}) - $signed({y0_ff[31], y0_ff});
      end
   end

   // divide and multiply
   assign trial = {rem_ff, q_ff[47]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};
   assign pp    = 48'(q_ff[47:32]) * 48'(mdy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.prep) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= status.div_last ? '0 : cnt_ff + pli_pkg::STEP_W'(1);
      end else if (cmd.mul_step) begin
         cnt_ff <= cnt_ff + pli_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         div_ff  <= mag33(dx_ff);
         mdy_ff  <= mag33(dy_ff);
         neg_ff  <= dx_ff[32] ^ num_ff[32] ^ dy_ff[32];
         q_ff    <= {mag33(num_ff), 16'h0000};
         rem_ff  <= '0;
         acc_ff  <= '0;
         res_ff  <= y0_ff;
         stat_ff <= (dx_ff == '0) ? pli_pkg::RS_ZERO :
                    above_ff      ? pli_pkg::RS_ABOVE :
                    below_ff      ? pli_pkg::RS_BELOW : pli_pkg::RS_INSIDE;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? diff[31:0] : trial[31:0];
         q_ff   <= {q_ff[46:0], ge};
      end
      if (cmd.mul_step) begin
         acc_ff <= {acc_ff[63:0], 16'h0000} + {32'h0, pp};
         q_ff   <= {q_ff[31:0], 16'h0000};
      end
      if (cmd.sum) begin
         res_ff <= sum_val;
      end
   end

   // y0 +/- (f*|dy| >> 16), saturated
   assign mp  = acc_ff[79:16];
   assign big = |mp[63:33];
   assign y0e = {{3{y0_ff[31]}}, y0_ff};
   assign mpe = {2'b00, mp[32:0]};
   assign s   = neg_ff ? (y0e - mpe) : (y0e + mpe);

   always_comb begin
      if (big) begin
         sum_val = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (s[34] && !(&s[33:31])) begin
         sum_val = 32'sh8000_0000;
      end else if (!s[34] && (|s[33:31])) begin
         sum_val = 32'sh7FFF_FFFF;
      end else begin
         sum_val = s[31:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.y_result     <= res_ff;
         rsp_data_ff.range_status <= stat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.seg_done = hit || last;
   assign status.seg_zero = dx_ff == '0;
   assign status.div_last = cnt_ff == pli_pkg::STEP_W'(pli_pkg::DIV_STEPS - 1);
   assign status.mul_last = cnt_ff == pli_pkg::STEP_W'(pli_pkg::MUL_STEPS - 1);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ----- rtl/piecewise_linear_interpolator_core.sv -----
// Piecewise linear interpolation table: a load request writes one breakpoint
// (x, y) and is taken in the cycle it is presented while the block is idle,
// so loads go back to back. A query request scans the x table one entry per
// cycle through the memory's read port, from entry 1 up to the first x not
// below the query or the last point, then fetches the two end points, runs
// (unless the segment has zero width) a 48-step restoring divider for the
// fraction and a 3-step 16x32 multiplier, and adds and saturates. The next
// request is taken from the cycle after the response is loaded. The result
// register lets a new request in while a response waits. csr_point_count may
// be written at any time the block is idle.
// Depends on pli_pkg, pli_ctl and pli_dp.
`default_nettype none

module piecewise_linear_interpolator_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  pli_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output pli_pkg::rsp_type  rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [6:0]         csr_point_count
);

   pli_pkg::dp_cmd_type    cmd;
   pli_pkg::dp_status_type status;
   logic                   req_is_query;

   assign csr_ready    = 1'b1;
   assign req_is_query = req_data.opcode == pli_pkg::OP_QUERY;

   pli_ctl u_ctl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_is_query (req_is_query),
      .status       (status),
      .req_ready    (req_ready),
      .cmd          (cmd)
   );

   pli_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_data        (req_data),
      .csr_wr          (csr_valid && csr_ready),
      .csr_point_count (csr_point_count),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/pli_checker.sv -----
// Port-level checks for the interpolator, bound onto the top level.
// Depends on pli_pkg and piecewise_linear_interpolator_core_defines.svh.
`default_nettype none
`include "piecewise_linear_interpolator_core_defines.svh"

module pli_port_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input pli_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input pli_pkg::rsp_type rsp_data
);

   `PLI_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data),
      "stalled response changed")
   `PLI_ASSERT_IMPLY(a_reset_empty, clock, 1'b0,
      $past(reset), !rsp_valid,
      "response valid after reset")
   `PLI_ASSERT_NEXT(a_query_busy, clock, reset,
      req_valid && req_ready && (req_data.opcode == pli_pkg::OP_QUERY), !req_ready,
      "request taken while query runs")
   `PLI_ASSERT_NEXT(a_load_ready, clock, reset,
      req_valid && req_ready && (req_data.opcode == pli_pkg::OP_LOAD), req_ready,
      "load stalled next request")
   `PLI_ASSERT_IMPLY(a_rsp_from_busy, clock, reset,
      $rose(rsp_valid), !$past(req_ready),
      "response without running query")

endmodule

bind piecewise_linear_interpolator_core pli_port_checker u_pli_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
